>>> sv/byte_ring_fifo_defines.svh
// ----------------------------------------------------------------------------
// byte_ring_fifo assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_DEFINES_SVH
`define BYTE_RING_FIFO_DEFINES_SVH

`ifndef SYNTHESIS
`define BRF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("byte_ring_fifo assertion failed");
`define BRF_ASSERT_CLK(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("byte_ring_fifo assertion failed");
`else
`define BRF_ASSERT(lbl, clk, rst_n, prop)
`define BRF_ASSERT_CLK(lbl, clk, prop)
`endif

`endif

>>> sv/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared modes, widths, state type and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

	localparam int CAP_W     = 11;
	localparam int COUNT_W   = 10;
	localparam int CAP_RESET = 1024;

	localparam logic [2:0] MODE_WRITE   = 3'd0;
	localparam logic [2:0] MODE_PEEK    = 3'd1;
	localparam logic [2:0] MODE_READ    = 3'd2;
	localparam logic [2:0] MODE_ADVANCE = 3'd3;
	localparam logic [2:0] MODE_CLEAR   = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_BURST = 2'b10
	} state_t;

	typedef struct packed {
		logic accept;
		logic cfg_wr;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic burst;
		logic last_step;
	} sts_t;

endpackage

`default_nettype wire

>>> sv/brf_ctrl.sv
// ----------------------------------------------------------------------------
// brf_ctrl
// Controller: handshakes, burst sequencing and response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire brf_pkg::sts_t sts,
	output brf_pkg::cmd_t      cmd
);

	brf_pkg::state_t state_q, state_d;
	logic            rsp_valid_q;
	logic            out_free;
	logic            idle;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign idle      = (state_q == brf_pkg::ST_IDLE);
	assign cfg_ready = idle;
	assign req_stall = !(idle && out_free);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.accept = req_valid && !req_stall;
		cmd.cfg_wr = cfg_valid && idle;
		cmd.step   = (state_q == brf_pkg::ST_BURST) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			brf_pkg::ST_IDLE: begin
				if (cmd.accept && sts.burst) state_d = brf_pkg::ST_BURST;
			end
			brf_pkg::ST_BURST: begin
				if (cmd.step && sts.last_step) state_d = brf_pkg::ST_IDLE;
			end
			default: state_d = brf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brf_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((cmd.accept && !sts.burst) || cmd.step) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/brf_datapath.sv
// ----------------------------------------------------------------------------
// brf_datapath
// Byte store, ring indices, count arithmetic and response payload registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_ring_fifo_defines.svh"

module brf_datapath #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire brf_pkg::cmd_t                cmd,
	output brf_pkg::sts_t                     sts,
	input  wire logic [2:0]                   mode,
	input  wire logic [7:0]                   write_byte,
	input  wire logic [brf_pkg::COUNT_W-1:0]  request_length,
	input  wire logic [brf_pkg::CAP_W-1:0]    capacity,
	output logic [7:0]                        read_byte,
	output logic                              byte_valid,
	output logic                              last,
	output logic [brf_pkg::COUNT_W-1:0]       transfer_count,
	output logic [brf_pkg::COUNT_W-1:0]       used_count,
	output logic [brf_pkg::COUNT_W-1:0]       free_count,
	output logic                              rejected
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = (CW > brf_pkg::CAP_W) ? CW + 1 : brf_pkg::CAP_W + 1;
	localparam int BW = $clog2(MAX_BURST + 1);
	localparam int NW = brf_pkg::COUNT_W;
	localparam logic [CW-1:0] CAP_RST =
		CW'((brf_pkg::CAP_RESET > DEPTH) ? DEPTH : brf_pkg::CAP_RESET);

	logic [7:0]    mem [DEPTH];
	logic [IW-1:0] wr_q, rd_q, pos_q;
	logic [CW-1:0] cap_q;
	logic [BW-1:0] remain_q;
	logic [7:0]    rdata_q;
	logic          bvalid_q, last_q, rej_q;
	logic [NW-1:0] xfer_q, used_q, free_q;

	logic [WW-1:0] wr_w, rd_w, cap_w, cfg_w, req_w;
	logic [WW-1:0] used_w, free_w, adv_n, burst_n;
	logic [WW-1:0] nxt_used, nxt_free, nxt_xfer;
	logic          nxt_rej;
	logic [CW-1:0] cap_new;
	logic [IW-1:0] wr_next, rd_adv, rd_burst, pos_next;
	logic          full;

	function automatic logic [IW-1:0] wrap(input logic [WW-1:0] idx,
		input logic [WW-1:0] n, input logic [WW-1:0] c);
		logic [WW-1:0] s;
		s = idx + n;
		if (s >= c) s = s - c;
		return s[IW-1:0];
	endfunction

	assign wr_w  = WW'(wr_q);
	assign rd_w  = WW'(rd_q);
	assign cap_w = WW'(cap_q);
	assign cfg_w = WW'(capacity);
	assign req_w = WW'(request_length);

	assign used_w  = (rd_w <= wr_w) ? (wr_w - rd_w) : (cap_w - rd_w + wr_w);
	assign free_w  = cap_w - WW'(1) - used_w;
	assign full    = (free_w == '0);
	assign adv_n   = (req_w > used_w) ? used_w : req_w;
	assign burst_n = (adv_n > WW'(MAX_BURST)) ? WW'(MAX_BURST) : adv_n;

	assign wr_next  = wrap(wr_w, WW'(1), cap_w);
	assign rd_adv   = wrap(rd_w, adv_n, cap_w);
	assign rd_burst = wrap(rd_w, burst_n, cap_w);
	assign pos_next = wrap(WW'(pos_q), WW'(1), cap_w);

	always_comb begin
		if (cfg_w < WW'(2)) begin
			cap_new = CW'(2);
		end else if (cfg_w > WW'(DEPTH)) begin
			cap_new = CW'(DEPTH);
		end else begin
			cap_new = cfg_w[CW-1:0];
		end
	end

	always_comb begin
		nxt_used = used_w;
		nxt_free = free_w;
		nxt_xfer = '0;
		nxt_rej  = 1'b0;
		case (mode)
			brf_pkg::MODE_WRITE: begin
				if (full) begin
					nxt_rej = 1'b1;
				end else begin
					nxt_used = used_w + WW'(1);
					nxt_free = free_w - WW'(1);
					nxt_xfer = WW'(1);
				end
			end
			brf_pkg::MODE_PEEK: begin
				nxt_xfer = burst_n;
			end
			brf_pkg::MODE_READ: begin
				nxt_used = used_w - burst_n;
				nxt_free = free_w + burst_n;
				nxt_xfer = burst_n;
			end
			brf_pkg::MODE_ADVANCE: begin
				nxt_used = used_w - adv_n;
				nxt_free = free_w + adv_n;
				nxt_xfer = adv_n;
			end
			brf_pkg::MODE_CLEAR: begin
				nxt_used = '0;
				nxt_free = cap_w - WW'(1);
				nxt_xfer = used_w;
			end
			default: begin
				nxt_xfer = '0;
			end
		endcase
	end

	always_comb begin
		sts.burst     = ((mode == brf_pkg::MODE_PEEK) || (mode == brf_pkg::MODE_READ))
			&& (burst_n != '0);
		sts.last_step = (remain_q == BW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cap_q <= CAP_RST;
		end else if (cmd.cfg_wr) begin
			cap_q <= cap_new;
			wr_q  <= '0;
			rd_q  <= '0;
		end else if (cmd.accept) begin
			case (mode)
				brf_pkg::MODE_WRITE: begin
					if (!full) wr_q <= wr_next;
				end
				brf_pkg::MODE_READ: begin
					rd_q <= rd_burst;
				end
				brf_pkg::MODE_ADVANCE: begin
					rd_q <= rd_adv;
				end
				brf_pkg::MODE_CLEAR: begin
					wr_q <= '0;
					rd_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (mode == brf_pkg::MODE_WRITE) && !full) begin
			mem[wr_q] <= write_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			rdata_q <= mem[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pos_q    <= rd_q;
			remain_q <= burst_n[BW-1:0];
			xfer_q   <= nxt_xfer[NW-1:0];
			used_q   <= nxt_used[NW-1:0];
			free_q   <= nxt_free[NW-1:0];
			rej_q    <= nxt_rej;
			bvalid_q <= 1'b0;
			last_q   <= 1'b1;
		end else if (cmd.step) begin
			pos_q    <= pos_next;
			remain_q <= remain_q - BW'(1);
			bvalid_q <= 1'b1;
			last_q   <= (remain_q == BW'(1));
		end
	end

	assign read_byte      = bvalid_q ? rdata_q : 8'd0;
	assign byte_valid     = bvalid_q;
	assign last           = last_q;
	assign transfer_count = xfer_q;
	assign used_count     = used_q;
	assign free_count     = free_q;
	assign rejected       = rej_q;

	`BRF_ASSERT(a_wr_in_ring, clk, arst_n, WW'(wr_q) < WW'(cap_q))
	`BRF_ASSERT(a_rd_in_ring, clk, arst_n, WW'(rd_q) < WW'(cap_q))
	`BRF_ASSERT(a_step_has_bytes, clk, arst_n, cmd.step |-> (remain_q != '0))

endmodule

`default_nettype wire

>>> sv/byte_ring_fifo.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Circular byte FIFO with peek, read, advance and clear, one slot kept empty.
// ----------------------------------------------------------------------------
// Write, advance, clear and unused modes take one transaction per cycle and
// return one response. Peek and read of n bytes (n clamped to the stored
// count and to MAX_BURST) stall new requests until done, returning one byte
// per cycle from the store's single registered read port; an empty peek or
// read returns one response without a byte. Response stall holds the block.
// Writing capacity (clamped to 2..DEPTH) empties the FIFO; accepted only
// while no burst is in progress. Store contents are not cleared at reset.
`default_nettype none

module byte_ring_fifo #(
	parameter int DEPTH     = 1024,
	parameter int MAX_BURST = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire logic [2:0]                   mode,
	input  wire logic [7:0]                   write_byte,
	input  wire logic [brf_pkg::COUNT_W-1:0]  request_length,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic [7:0]                        read_byte,
	output logic                              byte_valid,
	output logic                              last,
	output logic [brf_pkg::COUNT_W-1:0]       transfer_count,
	output logic [brf_pkg::COUNT_W-1:0]       used_count,
	output logic [brf_pkg::COUNT_W-1:0]       free_count,
	output logic                              rejected,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [brf_pkg::CAP_W-1:0]    capacity
);

	brf_pkg::cmd_t cmd;
	brf_pkg::sts_t sts;

	brf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	brf_datapath #(
		.DEPTH     (DEPTH),
		.MAX_BURST (MAX_BURST)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.mode           (mode),
		.write_byte     (write_byte),
		.request_length (request_length),
		.capacity       (capacity),
		.read_byte      (read_byte),
		.byte_valid     (byte_valid),
		.last           (last),
		.transfer_count (transfer_count),
		.used_count     (used_count),
		.free_count     (free_count),
		.rejected       (rejected)
	);

endmodule

`default_nettype wire
